// File: rtl/core/maze_dfs_explorer_macros.svh
// ----------------------------------------------------------------------------
// Maze DFS explorer assertion macros
// Shared concurrent assertion forms for the explorer RTL.
// ----------------------------------------------------------------------------
`ifndef MAZE_DFS_EXPLORER_MACROS_SVH
`define MAZE_DFS_EXPLORER_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define MDE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled in reset.
`define MDE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/core/mde_pkg.sv
// ----------------------------------------------------------------------------
// Maze DFS explorer package
// Grid and stack sizes, codes, entry types and neighbor helper.
// ----------------------------------------------------------------------------
package mde_pkg;

  localparam int GRID_SIDE   = 16;
  localparam int COORD_W     = $clog2(GRID_SIDE);
  localparam int CELLS       = GRID_SIDE * GRID_SIDE;
  localparam int CELL_AW     = 2 * COORD_W;
  localparam int STACK_DEPTH = 256;
  localparam int SP_W        = $clog2(STACK_DEPTH);
  localparam int CNT_W       = SP_W + 1;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [2:0] {
    CMD_FWD   = 3'd0,
    CMD_LEFT  = 3'd1,
    CMD_RIGHT = 3'd2,
    CMD_GOAL  = 3'd3,
    CMD_ERR   = 3'd4
  } cmd_e;

  typedef enum logic [1:0] {
    MODE_EXPLORE = 2'd0,
    MODE_BACK    = 2'd1,
    MODE_DONE    = 2'd2,
    MODE_ERROR   = 2'd3
  } mode_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_EXP, ST_SC_RD, ST_SC_CHK, ST_DE_TOP, ST_DE_DAT,
    ST_LEFT1, ST_LEFT2, ST_RT, ST_RT_DAT, ST_TURN, ST_FWD, ST_TOP_RD,
    ST_TOP_CHK, ST_EMIT1
  } state_e;

  localparam logic REG_GOAL_X = 1'b0;
  localparam logic REG_GOAL_Y = 1'b1;

  // walls indexed by absolute direction: 0 east, 1 north, 2 west, 3 south
  typedef struct packed {
    coord_t     x;
    coord_t     y;
    logic [3:0] walls;
  } br_entry_t;

  localparam int BR_W = $bits(br_entry_t);

  typedef struct packed {
    logic   ok;
    coord_t x;
    coord_t y;
  } nbr_t;

  typedef struct packed {
    logic               we;
    logic [CELL_AW-1:0] waddr;
    logic [CELL_AW-1:0] raddr;
  } vis_req_t;

  typedef struct packed {
    logic            we;
    logic [SP_W-1:0] waddr;
    br_entry_t       wdata;
    logic [SP_W-1:0] raddr;
  } br_req_t;

  typedef struct packed {
    logic            we;
    logic [SP_W-1:0] waddr;
    logic [1:0]      wdata;
    logic [SP_W-1:0] raddr;
  } mv_req_t;

  function automatic nbr_t mde_nbr(coord_t x, coord_t y, logic [1:0] d);
    nbr_t n;
    n.ok = 1'b1;
    n.x  = x;
    n.y  = y;
    case (d)
      2'd0: if (x == coord_t'(GRID_SIDE - 1)) n.ok = 1'b0; else n.x = x + coord_t'(1);
      2'd1: if (y == coord_t'(GRID_SIDE - 1)) n.ok = 1'b0; else n.y = y + coord_t'(1);
      2'd2: if (x == '0) n.ok = 1'b0; else n.x = x - coord_t'(1);
      default: if (y == '0) n.ok = 1'b0; else n.y = y - coord_t'(1);
    endcase
    return n;
  endfunction

endpackage

// File: rtl/core/mde_ifs.sv
// ----------------------------------------------------------------------------
// Maze DFS explorer channels
// Valid/ready interfaces for sensor items and command results.
// ----------------------------------------------------------------------------
interface mde_in_if;
  logic valid;
  logic ready;
  logic wall_left;
  logic wall_front;
  logic wall_right;
  logic wall_back;

  modport source (output valid, wall_left, wall_front, wall_right, wall_back, input ready);
  modport sink   (input valid, wall_left, wall_front, wall_right, wall_back, output ready);
endinterface

interface mde_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] command;
  logic [3:0] pos_x;
  logic [3:0] pos_y;
  logic [1:0] heading;
  logic       last;

  modport source (output valid, command, pos_x, pos_y, heading, last, input ready);
  modport sink   (input valid, command, pos_x, pos_y, heading, last, output ready);
endinterface

// File: rtl/core/mde_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module mde_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/core/mde_visited.sv
// ----------------------------------------------------------------------------
// Visited map
// One bit per cell; cleared by a sweep after reset, start cell set.
// ----------------------------------------------------------------------------
module mde_visited
  import mde_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  vis_req_t req_i,
  output logic     rdata_o,
  output logic     busy_o
);

  logic               mem [CELLS];
  logic [CELL_AW:0]   clr_q, clr_d;
  logic               we;
  logic [CELL_AW-1:0] waddr;
  logic               wdata;

  assign busy_o = !clr_q[CELL_AW];
  assign clr_d  = busy_o ? clr_q + 1'b1 : clr_q;

  always_comb begin
    if (busy_o) begin
      we    = 1'b1;
      waddr = clr_q[CELL_AW-1:0];
      wdata = (clr_q[CELL_AW-1:0] == '0);  // start cell
    end else begin
      we    = req_i.we;
      waddr = req_i.waddr;
      wdata = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= '0;
    end else begin
      clr_q <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_o <= mem[req_i.raddr];
  end

endmodule

// File: rtl/core/mde_ctrl.sv
// ----------------------------------------------------------------------------
// Maze DFS explorer sequencer
// Walks each item through memory reads, turns, moves and stack updates.
// ----------------------------------------------------------------------------
`include "maze_dfs_explorer_macros.svh"

module mde_ctrl
  import mde_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  mde_in_if.sink           in_if,
  mde_out_if.source        out_if,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [3:0]       cfg_data_i,
  input  logic             clr_busy_i,
  output vis_req_t         vis_req_o,
  input  logic             vis_rdata_i,
  output br_req_t          br_req_o,
  input  br_entry_t        br_rdata_i,
  output mv_req_t          mv_req_o,
  input  logic [1:0]       mv_rdata_i
);

  state_e          state_q, state_d;
  mode_e           mode_q, mode_d;
  coord_t          x_q, x_d, y_q, y_d, sx_q, sx_d, sy_q, sy_d;
  logic [1:0]      hd_q, hd_d, dir_q, dir_d, tgt_q, tgt_d;
  logic [CNT_W-1:0] mc_q, mc_d, bc_q, bc_d;
  logic [3:0]      walls_q, walls_d, sw_q, sw_d;
  logic            scan_br_q, scan_br_d, rt_q, rt_d, top_back_q, top_back_d;
  cmd_e            pend_q, pend_d;
  coord_t          gx_q, gy_q;

  logic            ov_q, ov_d, olast_q, olast_d;
  cmd_e            ocmd_q, ocmd_d;
  coord_t          ox_q, ox_d, oy_q, oy_d;
  logic [1:0]      oh_q, oh_d;

  logic            accept, slot_free, blocked, on_top, top_hit, is_goal, fail_rt;
  logic            emit, emit_last;
  cmd_e            emit_cmd;
  coord_t          emit_x, emit_y;
  logic [1:0]      emit_h, delta, dl, dr, db;
  logic [3:0]      rot_w;
  logic [CNT_W-1:0] bc_m1, mc_m1;
  nbr_t            scan_n, fwd_n;

  assign accept    = in_if.valid && in_if.ready;
  assign in_if.ready = (state_q == ST_IDLE);
  assign slot_free = !ov_q || out_if.ready;
  assign bc_m1     = bc_q - 1'b1;
  assign mc_m1     = mc_q - 1'b1;
  assign scan_n    = mde_nbr(sx_q, sy_q, dir_q);
  assign fwd_n     = mde_nbr(x_q, y_q, hd_q);
  assign blocked   = !scan_n.ok || sw_q[dir_q];
  assign on_top    = (x_q == sx_q) && (y_q == sy_q);
  assign top_hit   = (x_q == br_rdata_i.x) && (y_q == br_rdata_i.y);
  assign delta     = tgt_q - hd_q;
  assign fail_rt   = (bc_q == '0) || (mc_q == '0);
  assign is_goal   = (({1'b0, x_q} == {1'b0, gx_q}) || ({1'b0, x_q} == {1'b0, gx_q} + 1'b1)) &&
                     (({1'b0, y_q} == {1'b0, gy_q}) || ({1'b0, y_q} == {1'b0, gy_q} + 1'b1));

  // sensor bits are relative to heading; rotate to absolute directions
  assign dl = hd_q + 2'd1;
  assign db = hd_q + 2'd2;
  assign dr = hd_q + 2'd3;
  always_comb begin
    rot_w = '0;
    rot_w[hd_q] = rot_w[hd_q] | in_if.wall_front;
    rot_w[dl]   = rot_w[dl]   | in_if.wall_left;
    rot_w[db]   = rot_w[db]   | in_if.wall_back;
    rot_w[dr]   = rot_w[dr]   | in_if.wall_right;
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (!clr_busy_i) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) begin
          unique case (mode_q)
            MODE_EXPLORE: state_d = ST_EXP;
            MODE_BACK:    state_d = (bc_q == '0) ? ST_EMIT1 : ST_TOP_RD;
            default:      state_d = ST_EMIT1;
          endcase
        end
      end
      ST_EXP:    state_d = is_goal ? ST_EMIT1 : ST_SC_RD;
      ST_SC_RD: begin
        if (!blocked) state_d = ST_SC_CHK;
        else if (dir_q == 2'd3) state_d = ST_DE_TOP;
      end
      ST_SC_CHK: begin
        if (!vis_rdata_i) state_d = scan_br_q ? ST_LEFT1 : ST_TURN;
        else if (dir_q == 2'd3) state_d = ST_DE_TOP;
        else state_d = ST_SC_RD;
      end
      ST_DE_TOP: state_d = (bc_q == '0) ? ST_EMIT1 : ST_DE_DAT;
      ST_DE_DAT: state_d = ST_SC_RD;
      ST_LEFT1:  if (slot_free) state_d = ST_LEFT2;
      ST_LEFT2:  if (slot_free) state_d = on_top ? ST_IDLE : ST_RT;
      ST_RT:     state_d = fail_rt ? ST_EMIT1 : ST_RT_DAT;
      ST_RT_DAT: state_d = ST_TURN;
      ST_TURN:   if (delta == 2'd0) state_d = ST_FWD;
      ST_FWD:    if (slot_free) state_d = rt_q ? ST_TOP_RD : ST_IDLE;
      ST_TOP_RD: state_d = ST_TOP_CHK;
      ST_TOP_CHK: state_d = (!top_hit && top_back_q) ? ST_RT : ST_IDLE;
      ST_EMIT1:  if (slot_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath, memory requests and result emission
  always_comb begin
    mode_d = mode_q;  x_d = x_q;  y_d = y_q;  hd_d = hd_q;
    mc_d = mc_q;  bc_d = bc_q;  walls_d = walls_q;
    sx_d = sx_q;  sy_d = sy_q;  sw_d = sw_q;  dir_d = dir_q;  tgt_d = tgt_q;
    scan_br_d = scan_br_q;  rt_d = rt_q;  top_back_d = top_back_q;  pend_d = pend_q;
    vis_req_o = '0;  br_req_o = '0;  mv_req_o = '0;
    emit = 1'b0;  emit_last = 1'b0;  emit_cmd = CMD_FWD;
    emit_x = x_q;  emit_y = y_q;  emit_h = hd_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          walls_d = rot_w;
          unique case (mode_q)
            MODE_BACK: begin
              top_back_d = 1'b1;
              if (bc_q == '0) begin
                mode_d = MODE_ERROR;
                pend_d = CMD_ERR;
              end
            end
            MODE_DONE:  pend_d = CMD_GOAL;
            MODE_ERROR: pend_d = CMD_ERR;
            default: ;
          endcase
        end
      end
      ST_EXP: begin
        if (((walls_q & (walls_q - 4'd1)) == 4'd0) && !bc_q[CNT_W-1]) begin
          br_req_o.we    = 1'b1;
          br_req_o.waddr = bc_q[SP_W-1:0];
          br_req_o.wdata = '{x: x_q, y: y_q, walls: walls_q};
          bc_d           = bc_q + 1'b1;
        end
        if (is_goal) begin
          mode_d = MODE_DONE;
          pend_d = CMD_GOAL;
        end
        sx_d = x_q;  sy_d = y_q;  sw_d = walls_q;
        scan_br_d = 1'b0;  dir_d = 2'd0;
      end
      ST_SC_RD: begin
        vis_req_o.raddr = {scan_n.y, scan_n.x};
        if (blocked) begin
          dir_d = dir_q + 2'd1;
          if (dir_q == 2'd3 && scan_br_q) bc_d = bc_m1;  // exhausted branch
        end
      end
      ST_SC_CHK: begin
        if (!vis_rdata_i) begin
          tgt_d = dir_q;
          rt_d  = 1'b0;
        end else begin
          dir_d = dir_q + 2'd1;
          if (dir_q == 2'd3 && scan_br_q) bc_d = bc_m1;
        end
      end
      ST_DE_TOP: begin
        br_req_o.raddr = bc_m1[SP_W-1:0];
        if (bc_q == '0) begin
          mode_d = MODE_ERROR;
          pend_d = CMD_ERR;
        end
      end
      ST_DE_DAT: begin
        sx_d = br_rdata_i.x;  sy_d = br_rdata_i.y;  sw_d = br_rdata_i.walls;
        scan_br_d = 1'b1;  dir_d = 2'd0;
      end
      ST_LEFT1: begin
        if (slot_free) begin
          emit = 1'b1;  emit_cmd = CMD_LEFT;  emit_h = hd_q + 2'd1;
          hd_d = emit_h;
        end
      end
      ST_LEFT2: begin
        if (slot_free) begin
          emit = 1'b1;  emit_cmd = CMD_LEFT;  emit_h = hd_q + 2'd1;
          emit_last = on_top;
          hd_d = emit_h;
          if (on_top) begin
            bc_d   = bc_m1;
            mode_d = MODE_EXPLORE;
          end
        end
      end
      ST_RT: begin
        mv_req_o.raddr = mc_m1[SP_W-1:0];
        if (fail_rt) begin
          mode_d = MODE_ERROR;
          pend_d = CMD_ERR;
        end else begin
          mc_d = mc_m1;
        end
      end
      ST_RT_DAT: begin
        tgt_d = mv_rdata_i + 2'd2;
        rt_d  = 1'b1;
      end
      ST_TURN: begin
        if (delta != 2'd0 && slot_free) begin
          emit = 1'b1;
          // a half turn goes left when the target code is above the heading
          if (delta == 2'd1 || (delta == 2'd2 && hd_q < tgt_q)) begin
            emit_cmd = CMD_LEFT;  emit_h = hd_q + 2'd1;
          end else begin
            emit_cmd = CMD_RIGHT; emit_h = hd_q + 2'd3;
          end
          hd_d = emit_h;
        end
      end
      ST_FWD: begin
        if (slot_free) begin
          if (fwd_n.ok) begin
            emit_x = fwd_n.x;
            emit_y = fwd_n.y;
          end
          emit = 1'b1;  emit_cmd = CMD_FWD;  emit_last = 1'b1;
          x_d = emit_x;  y_d = emit_y;
          vis_req_o.we    = 1'b1;
          vis_req_o.waddr = {emit_y, emit_x};
          top_back_d      = 1'b0;
          if (!rt_q && !mc_q[CNT_W-1]) begin
            mv_req_o.we    = 1'b1;
            mv_req_o.waddr = mc_q[SP_W-1:0];
            mv_req_o.wdata = tgt_q;
            mc_d           = mc_q + 1'b1;
          end
        end
      end
      ST_TOP_RD: br_req_o.raddr = bc_m1[SP_W-1:0];
      ST_TOP_CHK: begin
        if (top_hit) begin
          bc_d   = bc_m1;
          mode_d = MODE_EXPLORE;
        end else begin
          mode_d = MODE_BACK;
        end
      end
      ST_EMIT1: begin
        if (slot_free) begin
          emit = 1'b1;  emit_cmd = pend_q;  emit_last = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // output register
  always_comb begin
    ov_d = ov_q && !out_if.ready;
    ocmd_d = ocmd_q;  ox_d = ox_q;  oy_d = oy_q;  oh_d = oh_q;  olast_d = olast_q;
    if (emit) begin
      ov_d = 1'b1;
      ocmd_d = emit_cmd;  ox_d = emit_x;  oy_d = emit_y;  oh_d = emit_h;
      olast_d = emit_last;
    end
  end

  assign out_if.valid   = ov_q;
  assign out_if.command = ocmd_q;
  assign out_if.pos_x   = ox_q;
  assign out_if.pos_y   = oy_q;
  assign out_if.heading = oh_q;
  assign out_if.last    = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      mode_q     <= MODE_EXPLORE;
      x_q        <= '0;
      y_q        <= '0;
      hd_q       <= 2'd1;
      mc_q       <= '0;
      bc_q       <= '0;
      ov_q       <= 1'b0;
      gx_q       <= coord_t'(7);
      gy_q       <= coord_t'(7);
    end else begin
      state_q <= state_d;
      mode_q  <= mode_d;
      x_q     <= x_d;
      y_q     <= y_d;
      hd_q    <= hd_d;
      mc_q    <= mc_d;
      bc_q    <= bc_d;
      ov_q    <= ov_d;
      if (cfg_we_i && cfg_idx_i == REG_GOAL_X) gx_q <= cfg_data_i;
      if (cfg_we_i && cfg_idx_i == REG_GOAL_Y) gy_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    walls_q    <= walls_d;
    sx_q       <= sx_d;
    sy_q       <= sy_d;
    sw_q       <= sw_d;
    dir_q      <= dir_d;
    tgt_q      <= tgt_d;
    scan_br_q  <= scan_br_d;
    rt_q       <= rt_d;
    top_back_q <= top_back_d;
    pend_q     <= pend_d;
    ocmd_q     <= ocmd_d;
    ox_q       <= ox_d;
    oy_q       <= oy_d;
    oh_q       <= oh_d;
    olast_q    <= olast_d;
  end

  `MDE_ASSERT_NXT(a_done_sticky, clk_i, rst_ni, mode_q == MODE_DONE, mode_q == MODE_DONE)
  `MDE_ASSERT_NXT(a_error_sticky, clk_i, rst_ni, mode_q == MODE_ERROR, mode_q == MODE_ERROR)
  `MDE_ASSERT_IMP(a_counts_bound, clk_i, rst_ni, 1'b1, bc_q <= CNT_W'(STACK_DEPTH) && mc_q <= CNT_W'(STACK_DEPTH))
  `MDE_ASSERT_IMP(a_no_emit_on_busy_slot, clk_i, rst_ni, emit, !ov_q || out_if.ready)

endmodule

// File: rtl/core/maze_dfs_explorer.sv
// ----------------------------------------------------------------------------
// Maze DFS explorer
// Depth-first micromouse exploration over a visited map and two stacks.
// ----------------------------------------------------------------------------
// After reset the block sweeps the 256-entry visited map, one cell per cycle,
// and takes no sensor transaction until the sweep ends. In an explore
// transaction the neighbor scan reads the visited map one neighbor cell at
// a time; each emitted command waits for a free output slot. A dead end
// inspects branch stack entries, each by a branch stack read and up to four
// visited-map reads. One transaction is worked at a time; goal_x and goal_y
// may be written only while the block is idle.
module maze_dfs_explorer
  import mde_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  mde_in_if.sink     in_if,
  mde_out_if.source  out_if,
  input  logic       cfg_we_i,
  input  logic       cfg_idx_i,
  input  logic [3:0] cfg_data_i
);

  vis_req_t   vis_req;
  br_req_t    br_req;
  mv_req_t    mv_req;
  logic       vis_rdata, clr_busy;
  br_entry_t  br_rdata;
  logic [1:0] mv_rdata;

  mde_visited u_visited (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (vis_req),
    .rdata_o (vis_rdata),
    .busy_o  (clr_busy)
  );

  mde_ram #(.Width(BR_W), .Depth(STACK_DEPTH)) u_branch_ram (
    .clk_i   (clk_i),
    .we_i    (br_req.we),
    .waddr_i (br_req.waddr),
    .wdata_i (br_req.wdata),
    .raddr_i (br_req.raddr),
    .rdata_o (br_rdata)
  );

  mde_ram #(.Width(2), .Depth(STACK_DEPTH)) u_move_ram (
    .clk_i   (clk_i),
    .we_i    (mv_req.we),
    .waddr_i (mv_req.waddr),
    .wdata_i (mv_req.wdata),
    .raddr_i (mv_req.raddr),
    .rdata_o (mv_rdata)
  );

  mde_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_if       (in_if),
    .out_if      (out_if),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .clr_busy_i  (clr_busy),
    .vis_req_o   (vis_req),
    .vis_rdata_i (vis_rdata),
    .br_req_o    (br_req),
    .br_rdata_i  (br_rdata),
    .mv_req_o    (mv_req),
    .mv_rdata_i  (mv_rdata)
  );

endmodule
